FILE: rtl/grcl_pkg.sv
// ----------------------------------------------------------------------------
// grcl_pkg
// Shared widths, codes and the item record of the gradient ramp pipeline.
// ----------------------------------------------------------------------------
package grcl_pkg;

	localparam int MAX_STOPS_DEF = 16;

	localparam int OFF_W    = 17;
	localparam int CH_W     = 16;
	localparam int COL_W    = 4 * CH_W;
	localparam int T_W      = 32;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 5;
	localparam int MODE_W   = 2;
	localparam int S_DATA_W = 120;
	localparam int M_DATA_W = 64;

	// spread modes
	localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PAD     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REPEAT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_REFLECT = 2'd3;

	// item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SHADE = 1'b1;

	// configuration register indexes
	localparam logic CFG_SPREAD     = 1'b0;
	localparam logic CFG_STOP_COUNT = 1'b1;

	// how a shade item finds its color
	localparam logic [1:0] KIND_ZERO   = 2'd0;
	localparam logic [1:0] KIND_DIRECT = 2'd1;
	localparam logic [1:0] KIND_BLEND  = 2'd2;

	localparam logic [OFF_W-1:0] ONE_Q16 = 17'h10000;

	// shade item as it travels through the divider and blend stages
	typedef struct packed {
		logic [1:0]       kind;
		logic [COL_W-1:0] col_a;
		logic [COL_W-1:0] col_b;
		logic [OFF_W-1:0] rem;
		logic [OFF_W-1:0] span;
		logic [OFF_W-1:0] quot;
	} grcl_item_t;

endpackage

FILE: rtl/gradient_ramp_color_lookup.sv
// ----------------------------------------------------------------------------
// gradient_ramp_color_lookup
// Gradient color ramp with spread modes over a table of up to MAX_STOPS stops.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  stop write or shade parameter
// m_*       out        m_tvalid/m_tready  shaded RGBA color
// cfg_*     in         cfg_valid/cfg_ready spread mode, stop count
//
// one item enters per cycle while no stall on m_tready holds the pipeline; a shade item
// passes 4 front stages, 17 divider stages and 2 blend stages
// stop writes update the table in stage 2 and produce no output
// arst_n clears all valid bits and the stop count, sets spread mode to pad; table is undefined
// a stall on m_tready holds every occupied stage, bubbles still close up
// ----------------------------------------------------------------------------
module gradient_ramp_color_lookup import grcl_pkg::*; #(
	parameter int MAX_STOPS = MAX_STOPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [CNT_W-1:0]    cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// stop_index, stop_offset, stop_red, stop_green, stop_blue, stop_alpha,
	// param_t, zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	// opcode
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// red, green, blue, alpha
	output logic [M_DATA_W-1:0] m_tdata
);

	logic       f_valid, f_ready, d_valid, d_ready;
	grcl_item_t f_item, d_item;

	assign cfg_ready = 1'b1;

	grcl_front #(.MAX_STOPS(MAX_STOPS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_valid   (s_tvalid),
		.s_ready   (s_tready),
		.s_data    (s_tdata),
		.s_opcode  (s_tuser),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item)
	);

	grcl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_item  (d_item)
	);

	grcl_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_item   (d_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

FILE: rtl/grcl_front.sv
// ----------------------------------------------------------------------------
// grcl_front
// Config registers, parameter wrap, stop table and stop search (four stages).
// ----------------------------------------------------------------------------
module grcl_front import grcl_pkg::*; #(
	parameter int MAX_STOPS = MAX_STOPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [CNT_W-1:0]    cfg_data,
	input  logic                s_valid,
	output logic                s_ready,
	input  logic [S_DATA_W-1:0] s_data,
	input  logic                s_opcode,
	output logic                out_valid,
	input  logic                out_ready,
	output grcl_item_t          out_item
);

	localparam int AW = $clog2(MAX_STOPS);
	localparam int NW = $clog2(MAX_STOPS + 1);

	logic [MODE_W-1:0] mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [NW-1:0]     n_c;

	logic              v_s1, op_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [OFF_W-1:0]  off_s1;
	logic [COL_W-1:0]  col_s1;
	logic [T_W-1:0]    t_s1;

	logic              v_s2, op_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [OFF_W-1:0]  off_s2;
	logic [COL_W-1:0]  col_s2;
	logic [OFF_W-1:0]  tw_s2;
	logic [1:0]        cls_s2;

	logic                    v_s3;
	logic [1:0]              kind_s3;
	logic [OFF_W+COL_W-1:0]  rda_s3, rdb_s3;

	logic              v_s4;
	grcl_item_t        item_s4;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	localparam logic [1:0] CLS_ZERO   = 2'd0;
	localparam logic [1:0] CLS_FIRST  = 2'd1;
	localparam logic [1:0] CLS_LAST   = 2'd2;
	localparam logic [1:0] CLS_LOOKUP = 2'd3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PAD;
			count_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SPREAD:     mode_q  <= cfg_data[MODE_W-1:0];
				CFG_STOP_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective stop count
	always_comb begin
		if (int'(count_q) > MAX_STOPS) n_c = NW'(MAX_STOPS);
		else n_c = NW'(count_q);
	end

	// stall chain
	assign rdy_s4  = !v_s4 || out_ready;
	assign rdy_s3  = !v_s3 || rdy_s4;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign s_ready = rdy_s1;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (rdy_s1) v_s1 <= s_valid;
	end

	always_ff @(posedge clk) begin
		if (s_valid && rdy_s1) begin
			op_s1  <= s_opcode;
			idx_s1 <= s_data[3:0];
			off_s1 <= s_data[20:4];
			col_s1 <= s_data[84:21];
			t_s1   <= s_data[116:85];
		end
	end

	// parameter wrap by spread mode
	logic [T_W:0]     mag_c;
	logic [OFF_W-1:0] refl_c, tw_c;
	logic [1:0]       cls_c;
	logic             neg_c, big_c;

	always_comb begin
		neg_c  = t_s1[T_W-1];
		big_c  = !neg_c && (t_s1[T_W-2:0] > 31'(ONE_Q16));
		mag_c  = neg_c ? ((T_W+1)'(0) - {t_s1[T_W-1], t_s1}) : {1'b0, t_s1};
		refl_c = mag_c[OFF_W-1:0];
		if (refl_c > ONE_Q16) refl_c = OFF_W'({1'b1, {OFF_W{1'b0}}} - {1'b0, refl_c});
		tw_c  = t_s1[OFF_W-1:0];
		cls_c = CLS_LOOKUP;
		case (mode_q)
			MODE_NONE: begin
				if (neg_c || big_c) cls_c = CLS_ZERO;
			end
			MODE_PAD: begin
				if (neg_c) cls_c = CLS_FIRST;
				else if (big_c) cls_c = CLS_LAST;
			end
			MODE_REPEAT: tw_c = {1'b0, t_s1[CH_W-1:0]};
			default:     tw_c = refl_c;
		endcase
		if (n_c == '0) cls_c = CLS_ZERO;
	end

	// stage 2: wrapped parameter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (rdy_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			off_s2 <= off_s1;
			col_s2 <= col_s1;
			tw_s2  <= tw_c;
			cls_s2 <= cls_c;
		end
	end

	// stop table: offsets in flops for the search, full entries in memory
	logic [OFF_W-1:0]       off_q [MAX_STOPS];
	logic [OFF_W+COL_W-1:0] mem_q [MAX_STOPS];
	logic                   wr_c, rd_c, found_c;
	logic [AW-1:0]          hit_c, last_c, addr_a_c, addr_b_c;
	logic [NW-1:0]          nm1_c;
	logic [1:0]             kind_c;

	assign wr_c = v_s2 && (op_s2 == OP_WRITE) && rdy_s2 && (int'(idx_s2) < MAX_STOPS);
	assign rd_c = v_s2 && (op_s2 == OP_SHADE) && rdy_s3;

	// first stop at or above the parameter
	always_comb begin
		found_c = 1'b0;
		hit_c   = '0;
		for (int j = MAX_STOPS - 1; j >= 0; j--) begin
			if ((NW'(j) < n_c) && (off_q[j] >= tw_s2)) begin
				found_c = 1'b1;
				hit_c   = AW'(j);
			end
		end
		nm1_c    = n_c - NW'(1);
		last_c   = nm1_c[AW-1:0];
		addr_a_c = '0;
		addr_b_c = hit_c;
		kind_c   = KIND_DIRECT;
		case (cls_s2)
			CLS_ZERO:  kind_c = KIND_ZERO;
			CLS_FIRST: addr_a_c = '0;
			CLS_LAST:  addr_a_c = last_c;
			default: begin
				if (!found_c) addr_a_c = last_c;
				else if (hit_c != '0) begin
					kind_c   = KIND_BLEND;
					addr_a_c = hit_c - AW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_c) begin
			off_q[AW'(idx_s2)] <= off_s2;
			mem_q[AW'(idx_s2)] <= {off_s2, col_s2};
		end
		if (rd_c) begin
			rda_s3  <= mem_q[addr_a_c];
			rdb_s3  <= mem_q[addr_b_c];
			kind_s3 <= kind_c;
		end
	end

	// stage 3: table read, write items end here
	logic [OFF_W-1:0] tw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (rdy_s3) v_s3 <= v_s2 && (op_s2 == OP_SHADE);
	end

	always_ff @(posedge clk) begin
		if (rd_c) tw_s3 <= tw_s2;
	end

	// stage 4: numerator and span for the weight division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (rdy_s4) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			item_s4.kind  <= kind_s3;
			item_s4.col_a <= rda_s3[COL_W-1:0];
			item_s4.col_b <= rdb_s3[COL_W-1:0];
			item_s4.rem   <= tw_s3 - rda_s3[OFF_W+COL_W-1:COL_W];
			item_s4.span  <= rdb_s3[OFF_W+COL_W-1:COL_W] - rda_s3[OFF_W+COL_W-1:COL_W];
			item_s4.quot  <= '0;
		end
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;

`ifndef SYNTHESIS
	a_write_ends: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && (op_s2 == OP_WRITE) |=> v_s3 == $past(v_s3 && !rdy_s4))
		else $error("write item reached the read stage");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && found_c |-> (NW'(hit_c) < n_c))
		else $error("stop search hit beyond the stop count");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !out_ready |=> v_s4 && $stable(item_s4))
		else $error("stalled item changed in stage 4");
`endif

endmodule

FILE: rtl/grcl_div.sv
// ----------------------------------------------------------------------------
// grcl_div
// Pipelined restoring divider, one quotient bit per stage, for the Q1.16
// blend weight; the colors ride along with the item.
// ----------------------------------------------------------------------------
module grcl_div import grcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  grcl_item_t in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output grcl_item_t out_item
);

	localparam int STEPS = OFF_W;

	logic       v_sk    [STEPS];
	grcl_item_t item_sk [STEPS];
	logic       rdy     [STEPS];

	genvar g;
	generate
		for (g = 0; g < STEPS; g++) begin : g_step
			logic       vin;
			grcl_item_t src, nxt;
			logic [OFF_W:0] sh;

			if (g == 0) begin : g_first
				assign vin = in_valid;
				assign src = in_item;
			end else begin : g_next
				assign vin = v_sk[g-1];
				assign src = item_sk[g-1];
			end

			if (g == STEPS - 1) begin : g_last
				assign rdy[g] = !v_sk[g] || out_ready;
			end else begin : g_mid
				assign rdy[g] = !v_sk[g] || rdy[g+1];
			end

			// one compare and subtract step
			always_comb begin
				nxt = src;
				if (g == 0) sh = {1'b0, src.rem};
				else sh = {src.rem, 1'b0};
				if (sh >= {1'b0, src.span}) begin
					nxt.rem = OFF_W'(sh - {1'b0, src.span});
					nxt.quot[STEPS-1-g] = 1'b1;
				end else begin
					nxt.rem = sh[OFF_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_sk[g] <= 1'b0;
				else if (rdy[g]) v_sk[g] <= vin;
			end

			always_ff @(posedge clk) begin
				if (vin && rdy[g]) item_sk[g] <= nxt;
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = v_sk[STEPS-1];
	assign out_item  = item_sk[STEPS-1];

endmodule

FILE: rtl/grcl_blend.sv
// ----------------------------------------------------------------------------
// grcl_blend
// Weighted mix of two stop colors: product stage, then sum and output
// register.
// ----------------------------------------------------------------------------
module grcl_blend import grcl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  grcl_item_t          in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [M_DATA_W-1:0] out_data
);

	logic                 v_s1, v_s2;
	logic [1:0]           kind_s1;
	logic [COL_W-1:0]     col_s1;
	logic [2*CH_W:0]      pa_s1 [4];
	logic [2*CH_W:0]      pb_s1 [4];
	logic [M_DATA_W-1:0]  data_s2;
	logic                 rdy_s1, rdy_s2;
	logic [OFF_W-1:0]     winv_c;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign winv_c   = ONE_Q16 - in_item.quot;

	// stage 1: per-channel products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (rdy_s1) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			kind_s1 <= in_item.kind;
			col_s1  <= in_item.col_a;
			for (int k = 0; k < 4; k++) begin
				pa_s1[k] <= in_item.col_a[k*CH_W +: CH_W] * winv_c;
				pb_s1[k] <= in_item.col_b[k*CH_W +: CH_W] * in_item.quot;
			end
		end
	end

	// stage 2: sum, scale and select
	logic [M_DATA_W-1:0] mix_c;
	logic [2*CH_W+1:0]   sum_c;

	always_comb begin
		mix_c = '0;
		for (int k = 0; k < 4; k++) begin
			sum_c = {1'b0, pa_s1[k]} + {1'b0, pb_s1[k]};
			mix_c[k*CH_W +: CH_W] = sum_c[2*CH_W-1:CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (rdy_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			case (kind_s1)
				KIND_ZERO:   data_s2 <= '0;
				KIND_DIRECT: data_s2 <= col_s1;
				default:     data_s2 <= mix_c;
			endcase
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule
